// ----- design/iafmt_pkg.sv -----
package iafmt_pkg;

   localparam int BIN_W    = 32;
   localparam int NUM_DIG  = 10;
   localparam int BCD_W    = 4 * NUM_DIG;
   localparam int WORK_W   = BCD_W + BIN_W;
   localparam int STEP_W   = $clog2(BIN_W + 1);
   localparam int PTR_BODY = 11;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOW_X = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   typedef enum logic [1:0] {
      OP_DEC = 2'd0,
      OP_HEX = 2'd1,
      OP_PTR = 2'd2,
      OP_CHR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_PREFIX,
      ST_BODY,
      ST_CHAR
   } state_type;

   typedef struct packed {
      logic              start;
      logic              decimal;
      logic [BIN_W-1:0]  value;
   } cvt_req_type;

   // one shift-and-add-3 step of the binary to BCD conversion
   function automatic logic [WORK_W-1:0] dabble_step(input logic [WORK_W-1:0] w);
      logic [WORK_W-1:0] t;
      t = w;
      for (int i = 0; i < NUM_DIG; i++) begin
         if (t[BIN_W + 4*i +: 4] >= 4'd5) begin
            t[BIN_W + 4*i +: 4] = t[BIN_W + 4*i +: 4] + 4'd3;
         end
      end
      return {t[WORK_W-2:0], 1'b0};
   endfunction

   // significant digit count, at least one
   function automatic logic [3:0] digit_len(input logic [BCD_W-1:0] d);
      logic [3:0] n;
      n = 4'd1;
      for (int i = 1; i < NUM_DIG; i++) begin
         if (d[4*i +: 4] != 4'd0) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

   function automatic logic [3:0] digit_at(input logic [BCD_W-1:0] d, input logic [3:0] k);
      logic [3:0] r;
      r = 4'd0;
      for (int i = 0; i < NUM_DIG; i++) begin
         if (k == 4'(i)) begin
            r = d[4*i +: 4];
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = CH_ZERO + {4'd0, n};
      end else begin
         c = CH_SEVEN + {4'd0, n};
      end
      return c;
   endfunction

endpackage

// ----- design/iafmt_bcd_unit.sv -----
module iafmt_bcd_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  iafmt_pkg::cvt_req_type          cvt_req,
   output logic                            busy,
   output logic [iafmt_pkg::BCD_W-1:0]     digits
);
   import iafmt_pkg::*;

   logic [WORK_W-1:0] work_ff, work_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   always_comb begin
      work_in = work_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cvt_req.start) begin
         if (cvt_req.decimal) begin
            work_in = {{BCD_W{1'b0}}, cvt_req.value};
            cnt_in  = STEP_W'(BIN_W);
            busy_in = 1'b1;
         end else begin
            // hex nibbles go straight to the digit field
            work_in = {8'h00, cvt_req.value, {BIN_W{1'b0}}};
            cnt_in  = '0;
            busy_in = 1'b0;
         end
      end else if (busy_ff) begin
         work_in = dabble_step(work_ff);
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
   end

   assign busy   = busy_ff;
   assign digits = work_ff[WORK_W-1:BIN_W];

endmodule

// ----- design/integer_to_ascii_formatter.sv -----
// Formats one 32-bit value per request as ASCII text, one character per
// response item, with rsp_last_char on the final one. Operation 0 gives
// decimal, 1 gives "0x" and upper-case hex, both zero padded to min_width
// (capped at MAX_WIDTH); 2 gives the 14-character pointer text; 3 gives the
// low byte. req_stall stays high from accept until the last character is in
// the output register. Decimal requests first pass through the
// shift-and-add-3 converter, while other modes load their value into its
// digit field directly.
module integer_to_ascii_formatter #(
   parameter int MAX_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_value,
   input  logic [5:0]  req_min_width,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_character,
   output logic        rsp_last_char
);
   import iafmt_pkg::*;

   localparam int IDX_W = $clog2(MAX_WIDTH + 1);

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [IDX_W-1:0]  width_ff, idx_ff;
   logic [3:0]        len_ff, len_now;
   logic [1:0]        pre_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_char_ff;
   logic              rsp_last_ff;

   logic              accept, out_free, emit, emit_last;
   logic [7:0]        emit_char;
   logic [1:0]        pre_last;
   logic [IDX_W-1:0]  len_ext, body_top;
   logic              cvt_busy;
   logic [BCD_W-1:0]  digits;
   cvt_req_type       cvt_req;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign len_now  = digit_len(digits);
   assign len_ext  = IDX_W'(len_now);
   assign pre_last = (op_ff == OP_PTR) ? 2'd2 : 2'd1;

   always_comb begin
      if (op_ff == OP_PTR) begin
         body_top = IDX_W'(PTR_BODY - 1);
      end else if (width_ff > len_ext) begin
         body_top = width_ff - 1'b1;
      end else begin
         body_top = len_ext - 1'b1;
      end
   end

   assign cvt_req.start   = accept;
   assign cvt_req.decimal = (op_type'(req_operation) == OP_DEC);
   assign cvt_req.value   = req_value;

   iafmt_bcd_unit u_bcd (
      .clock   (clock),
      .reset   (reset),
      .cvt_req (cvt_req),
      .busy    (cvt_busy),
      .digits  (digits)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (!cvt_busy) state_in = ST_MEASURE;
         end
         ST_MEASURE: begin
            if (op_ff == OP_CHR) begin
               state_in = ST_CHAR;
            end else if (op_ff == OP_DEC) begin
               state_in = ST_BODY;
            end else begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (out_free && pre_ff == pre_last) state_in = ST_BODY;
         end
         ST_BODY: begin
            if (out_free && idx_ff == '0) state_in = ST_IDLE;
         end
         ST_CHAR: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // character selection
   always_comb begin
      emit      = 1'b0;
      emit_last = 1'b0;
      emit_char = CH_ZERO;
      case (state_ff)
         ST_PREFIX: begin
            emit = out_free;
            case (pre_ff)
               2'd0:    emit_char = CH_ZERO;
               2'd1:    emit_char = (op_ff == OP_HEX) ? CH_LOW_X : CH_UP_X;
               default: emit_char = CH_SEVEN;
            endcase
         end
         ST_BODY: begin
            emit      = out_free;
            emit_last = (idx_ff == '0);
            if (idx_ff < IDX_W'(len_ff)) begin
               emit_char = hex_char(digit_at(digits, idx_ff[3:0]));
            end else if (op_ff == OP_PTR) begin
               emit_char = CH_UP_F;
            end else begin
               emit_char = CH_ZERO;
            end
         end
         ST_CHAR: begin
            emit      = out_free;
            emit_last = 1'b1;
            emit_char = digits[7:0];
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
      end
      if (accept) begin
         op_ff <= op_type'(req_operation);
         if (req_min_width > 6'(MAX_WIDTH)) begin
            width_ff <= IDX_W'(MAX_WIDTH);
         end else begin
            width_ff <= req_min_width[IDX_W-1:0];
         end
      end
      if (state_ff == ST_MEASURE) begin
         // a zero pointer keeps every 'F'
         len_ff <= (op_ff == OP_PTR && digits == '0) ? 4'd0 : len_now;
         idx_ff <= body_top;
         pre_ff <= 2'd0;
      end else if (emit && state_ff == ST_PREFIX) begin
         pre_ff <= pre_ff + 1'b1;
      end else if (emit && state_ff == ST_BODY) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

// ----- design/iafmt_checker.sv -----
module iafmt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_operation,
   input logic [31:0] req_value,
   input logic [5:0]  req_min_width,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_character,
   input logic        rsp_last_char
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after item accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_character) && $stable(rsp_last_char))
      else $error("stalled response item changed");

   a_mid_item_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |-> req_stall)
      else $error("ready while item text incomplete");

   a_ready_on_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(req_stall) |-> rsp_valid && rsp_last_char)
      else $error("ready without last character");

endmodule

bind integer_to_ascii_formatter iafmt_checker u_iafmt_checker (.*);
